// ===== design/mbc_pkg.sv =====
package mbc_pkg;

    // width used for grid dimension compares (covers MAX_ROWS/MAX_COLS up to 256)
    localparam int DIM_W = 9;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [1:0] {
        EV_STARTED   = 2'd0,
        EV_CARVED    = 2'd1,
        EV_BACKTRACK = 2'd2,
        EV_FINISHED  = 2'd3
    } ev_kind_t;

    // neighbor order: down, up, right, left
    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_UP    = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        C_NO_IN    = 3'd0,
        C_START    = 3'd1,
        C_SP_ZERO  = 3'd2,
        C_NO_CAND  = 3'd3,
        C_CLR_MORE = 3'd4,
        C_OUT_BUSY = 3'd5
    } cond_t;

    typedef enum logic [1:0] {
        J_NEXT   = 2'd0,
        J_ALWAYS = 2'd1,
        J_IF     = 2'd2
    } jmp_t;

    typedef logic [3:0] upc_t;

    // microprogram addresses
    localparam upc_t UA_FETCH = 4'd0;
    localparam upc_t UA_DISP  = 4'd1;
    localparam upc_t UA_LOADC = 4'd2;
    localparam upc_t UA_RD_D  = 4'd3;
    localparam upc_t UA_RD_U  = 4'd4;
    localparam upc_t UA_RD_R  = 4'd5;
    localparam upc_t UA_RD_L  = 4'd6;
    localparam upc_t UA_CAP_L = 4'd7;
    localparam upc_t UA_CARVE = 4'd8;
    localparam upc_t UA_CLR   = 4'd9;
    localparam upc_t UA_START = 4'd10;
    localparam upc_t UA_POP   = 4'd13;
    localparam upc_t UA_TOP   = 4'd14;
    localparam upc_t UA_EMIT  = 4'd15;

    typedef struct packed {
        logic     fetch;     // input request may be taken
        logic     stk_rd;    // read stack entry at depth-1
        logic     load_cur;  // current cell from stack read data
        logic     vis_rd;    // read visited bit of neighbor rd_dir
        dir_t     rd_dir;
        logic     cap;       // capture candidate bit for cap_dir
        dir_t     cap_dir;
        logic     clr_wr;    // clear one visited entry
        logic     start_wr;  // mark start cell, push it
        logic     carve;     // mark and push chosen neighbor
        logic     pop;       // drop stack top
        logic     set_kind;  // load event kind, clear anchor
        ev_kind_t kind;
        logic     emit;      // load output register
        jmp_t     jmp;
        cond_t    cond;
        upc_t     target;
    } ucode_t;

    // control store
    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        w = '0;
        unique case (addr)
            UA_FETCH: begin
                w.fetch = 1'b1;
                w.jmp = J_IF; w.cond = C_NO_IN; w.target = UA_FETCH;
            end
            UA_DISP: begin
                w.stk_rd = 1'b1;
                w.jmp = J_IF; w.cond = C_START; w.target = UA_CLR;
            end
            UA_LOADC: begin
                w.load_cur = 1'b1;
                w.set_kind = 1'b1; w.kind = EV_FINISHED;
                w.jmp = J_IF; w.cond = C_SP_ZERO; w.target = UA_TOP;
            end
            UA_RD_D: begin
                w.vis_rd = 1'b1; w.rd_dir = DIR_DOWN;
            end
            UA_RD_U: begin
                w.vis_rd = 1'b1; w.rd_dir = DIR_UP;
                w.cap = 1'b1; w.cap_dir = DIR_DOWN;
            end
            UA_RD_R: begin
                w.vis_rd = 1'b1; w.rd_dir = DIR_RIGHT;
                w.cap = 1'b1; w.cap_dir = DIR_UP;
            end
            UA_RD_L: begin
                w.vis_rd = 1'b1; w.rd_dir = DIR_LEFT;
                w.cap = 1'b1; w.cap_dir = DIR_RIGHT;
            end
            UA_CAP_L: begin
                w.cap = 1'b1; w.cap_dir = DIR_LEFT;
                w.jmp = J_IF; w.cond = C_NO_CAND; w.target = UA_POP;
            end
            UA_CARVE: begin
                w.carve = 1'b1;
                w.jmp = J_ALWAYS; w.target = UA_TOP;
            end
            UA_CLR: begin
                w.clr_wr = 1'b1;
                w.jmp = J_IF; w.cond = C_CLR_MORE; w.target = UA_CLR;
            end
            UA_START: begin
                w.start_wr = 1'b1;
                w.set_kind = 1'b1; w.kind = EV_STARTED;
                w.jmp = J_ALWAYS; w.target = UA_TOP;
            end
            UA_POP: begin
                w.pop = 1'b1;
                w.set_kind = 1'b1; w.kind = EV_BACKTRACK;
            end
            UA_TOP: begin
                w.stk_rd = 1'b1;
            end
            UA_EMIT: begin
                w.emit = 1'b1;
                w.jmp = J_IF; w.cond = C_OUT_BUSY; w.target = UA_EMIT;
            end
            default: begin
                w.jmp = J_ALWAYS; w.target = UA_FETCH;
            end
        endcase
        return w;
    endfunction

    // value mod 3: base-4 digits all weigh 1 mod 3
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [3:0] t;
        logic [2:0] u;
        s = 5'd0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 4'(s[4:2]) + 4'(s[1:0]);
        u = 3'(t[3:2]) + 3'(t[1:0]);
        if (u >= 3'd3) begin
            u = u - 3'd3;
        end
        return u[1:0];
    endfunction

    // candidate selected by random value mod candidate count
    function automatic dir_t pick_dir(input logic [3:0] mask, input logic [1:0] lo,
                                      input logic [1:0] m3);
        logic [2:0] n;
        logic [1:0] k;
        logic [2:0] seen;
        dir_t       d_sel;
        n = 3'($countones(mask));
        case (n)
            3'd2:    k = {1'b0, lo[0]};
            3'd3:    k = m3;
            3'd4:    k = lo;
            default: k = 2'd0;
        endcase
        seen  = 3'd0;
        d_sel = DIR_DOWN;
        for (int i = 0; i < 4; i++) begin
            if (mask[i]) begin
                if (seen == {1'b0, k}) begin
                    d_sel = dir_t'(2'(i));
                end
                seen = seen + 3'd1;
            end
        end
        return d_sel;
    endfunction

endpackage

// ===== design/maze_backtracker_carver.sv =====
// Recursive backtracker maze carver. A request with mode 0 clears the visited
// store, marks the start cell (saturated into the grid) and pushes it; a request
// with mode 1 does one carving step from the cell on top of the path stack and
// reports a carved passage, a backtrack, or finished when the stack is empty.
// Every request gives exactly one result. A short microprogram sequences a
// single-port visited memory and a path stack memory. In a step the four
// neighbor visited bits are read one per cycle through the single read port.
// A start first runs a clearing pass over every entry of the visited store,
// one entry per cycle. Configuration writes are taken in any cycle. A result
// waits in the output register while the next request is accepted; the block
// stalls only if the next result is ready before the previous one has been
// taken.
module maze_backtracker_carver
    import mbc_pkg::*;
#(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [5:0]  cfg_wdata,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // start_row[4:0], start_col[9:5], random_value[25:10]
    input  logic        s_tuser,   // mode[0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // top_row[4:0], top_col[9:5], anchor_row[14:10],
                                   // anchor_col[19:15], carve_down[20], stack_depth[31:21]
    output logic [1:0]  m_tuser    // event_kind[1:0]
);

    localparam int RW        = $clog2(MAX_ROWS);
    localparam int CW        = $clog2(MAX_COLS);
    localparam int CELL_W    = RW + CW;
    localparam int VIS_DEPTH = 1 << CELL_W;
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int SA_W      = $clog2(CELLS);
    localparam int SP_W      = $clog2(CELLS + 1);

    // control and configuration state
    upc_t             upc_reg, upc_next;
    logic [5:0]       rows_cfg_reg, rows_cfg_next;
    logic [5:0]       cols_cfg_reg, cols_cfg_next;
    logic [SP_W-1:0]  sp_reg, sp_next;
    logic [CELL_W-1:0] clr_reg, clr_next;
    logic             m_valid_reg, m_valid_next;

    // payload registers
    logic             mode_reg, mode_next;
    logic [4:0]       srow_reg, srow_next;
    logic [4:0]       scol_reg, scol_next;
    logic [1:0]       rv_lo_reg, rv_lo_next;
    logic [1:0]       rv_m3_reg, rv_m3_next;
    logic [RW-1:0]    cur_row_reg, cur_row_next;
    logic [CW-1:0]    cur_col_reg, cur_col_next;
    logic [3:0]       cand_reg, cand_next;
    ev_kind_t         kind_reg, kind_next;
    logic [RW-1:0]    anc_row_reg, anc_row_next;
    logic [CW-1:0]    anc_col_reg, anc_col_next;
    logic             down_reg, down_next;
    logic [31:0]      m_data_reg, m_data_next;
    logic [1:0]       m_user_reg, m_user_next;

    // memories
    logic              vis_mem [VIS_DEPTH];
    logic [CELL_W-1:0] stk_mem [CELLS];
    logic              vis_q;
    logic [CELL_W-1:0] stk_q;

    // memory ports
    logic              vis_we, vis_wdata;
    logic [CELL_W-1:0] vis_waddr, vis_raddr;
    logic              stk_we;
    logic [SA_W-1:0]   stk_waddr, stk_raddr;
    logic [CELL_W-1:0] stk_wdata;

    // datapath nets
    ucode_t            uw;
    logic              cond_hit;
    logic              s_accept;
    logic              out_busy;
    logic [DIM_W-1:0]  rows_eff, cols_eff;
    logic [DIM_W-1:0]  r9, c9, srow9, scol9, rsat9, csat9;
    logic [3:0]        in_range;
    logic [3:0]        mask_now;
    logic [RW-1:0]     row_up, row_dn;
    logic [CW-1:0]     col_lt, col_rt;
    logic [RW-1:0]     rd_row, new_row;
    logic [CW-1:0]     rd_col, new_col;
    dir_t              sel_dir;
    logic [SP_W-1:0]   sp_dec;
    logic [RW-1:0]     top_row_c;
    logic [CW-1:0]     top_col_c;
    logic [RW+4:0]     top_row_w, anc_row_w;
    logic [CW+4:0]     top_col_w, anc_col_w;
    logic [SP_W+10:0]  depth_w;

    assign uw       = ucode_rom(upc_reg);
    assign s_tready = uw.fetch;
    assign s_accept = s_tvalid && s_tready;
    assign out_busy = m_valid_reg && !m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // effective grid size: zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (rows_cfg_reg == 6'd0) begin
            rows_eff = DIM_W'(1);
        end else if (DIM_W'(rows_cfg_reg) > DIM_W'(MAX_ROWS)) begin
            rows_eff = DIM_W'(MAX_ROWS);
        end else begin
            rows_eff = DIM_W'(rows_cfg_reg);
        end
        if (cols_cfg_reg == 6'd0) begin
            cols_eff = DIM_W'(1);
        end else if (DIM_W'(cols_cfg_reg) > DIM_W'(MAX_COLS)) begin
            cols_eff = DIM_W'(MAX_COLS);
        end else begin
            cols_eff = DIM_W'(cols_cfg_reg);
        end
    end

    // neighbor coordinates and range tests against the current registers
    always_comb begin
        r9     = DIM_W'(cur_row_reg);
        c9     = DIM_W'(cur_col_reg);
        row_dn = cur_row_reg + RW'(1);
        row_up = cur_row_reg - RW'(1);
        col_rt = cur_col_reg + CW'(1);
        col_lt = cur_col_reg - CW'(1);
        in_range[DIR_DOWN]  = (r9 + DIM_W'(1) < rows_eff) && (c9 < cols_eff);
        in_range[DIR_UP]    = (r9 != '0) && (r9 - DIM_W'(1) < rows_eff) && (c9 < cols_eff);
        in_range[DIR_RIGHT] = (c9 + DIM_W'(1) < cols_eff) && (r9 < rows_eff);
        in_range[DIR_LEFT]  = (c9 != '0) && (c9 - DIM_W'(1) < cols_eff) && (r9 < rows_eff);
    end

    // start cell saturated into the grid
    always_comb begin
        srow9 = DIM_W'(srow_reg);
        scol9 = DIM_W'(scol_reg);
        rsat9 = (srow9 >= rows_eff) ? rows_eff - DIM_W'(1) : srow9;
        csat9 = (scol9 >= cols_eff) ? cols_eff - DIM_W'(1) : scol9;
    end

    // visited read address for the neighbor under test
    always_comb begin
        case (uw.rd_dir)
            DIR_DOWN:  begin rd_row = row_dn;      rd_col = cur_col_reg; end
            DIR_UP:    begin rd_row = row_up;      rd_col = cur_col_reg; end
            DIR_RIGHT: begin rd_row = cur_row_reg; rd_col = col_rt;      end
            default:   begin rd_row = cur_row_reg; rd_col = col_lt;      end
        endcase
        vis_raddr = {rd_row, rd_col};
    end

    // candidate mask including the bit being captured now
    always_comb begin
        mask_now = cand_reg;
        if (uw.cap) begin
            mask_now[uw.cap_dir] = in_range[uw.cap_dir] && !vis_q;
        end
    end

    // chosen neighbor
    always_comb begin
        sel_dir = pick_dir(cand_reg, rv_lo_reg, rv_m3_reg);
        case (sel_dir)
            DIR_DOWN:  begin new_row = row_dn;      new_col = cur_col_reg; end
            DIR_UP:    begin new_row = row_up;      new_col = cur_col_reg; end
            DIR_RIGHT: begin new_row = cur_row_reg; new_col = col_rt;      end
            default:   begin new_row = cur_row_reg; new_col = col_lt;      end
        endcase
    end

    // jump condition
    always_comb begin
        case (uw.cond)
            C_NO_IN:    cond_hit = !s_tvalid;
            C_START:    cond_hit = !mode_reg;
            C_SP_ZERO:  cond_hit = (sp_reg == '0);
            C_NO_CAND:  cond_hit = (mask_now == 4'd0);
            C_CLR_MORE: cond_hit = (clr_reg != '1);
            C_OUT_BUSY: cond_hit = out_busy;
            default:    cond_hit = 1'b0;
        endcase
    end

    // result fields
    always_comb begin
        top_row_c = (sp_reg != '0) ? stk_q[CELL_W-1:CW] : '0;
        top_col_c = (sp_reg != '0) ? stk_q[CW-1:0] : '0;
        top_row_w = (RW+5)'(top_row_c);
        top_col_w = (CW+5)'(top_col_c);
        anc_row_w = (RW+5)'(anc_row_reg);
        anc_col_w = (CW+5)'(anc_col_reg);
        depth_w   = (SP_W+11)'(sp_reg);
    end

    assign sp_dec    = sp_reg - SP_W'(1);
    assign stk_raddr = sp_dec[SA_W-1:0];

    // sequencer, datapath and memory write ports
    always_comb begin
        upc_next      = upc_reg;
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;
        sp_next       = sp_reg;
        clr_next      = clr_reg;
        m_valid_next  = m_valid_reg;
        mode_next     = mode_reg;
        srow_next     = srow_reg;
        scol_next     = scol_reg;
        rv_lo_next    = rv_lo_reg;
        rv_m3_next    = rv_m3_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        cand_next     = cand_reg;
        kind_next     = kind_reg;
        anc_row_next  = anc_row_reg;
        anc_col_next  = anc_col_reg;
        down_next     = down_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        vis_we        = 1'b0;
        vis_waddr     = clr_reg;
        vis_wdata     = 1'b0;
        stk_we        = 1'b0;
        stk_waddr     = sp_reg[SA_W-1:0];
        stk_wdata     = {new_row, new_col};

        // next microprogram address
        unique case (uw.jmp)
            J_NEXT:   upc_next = upc_reg + 4'd1;
            J_ALWAYS: upc_next = uw.target;
            J_IF:     upc_next = cond_hit ? uw.target : upc_reg + 4'd1;
            default:  upc_next = UA_FETCH;
        endcase

        // configuration writes
        if (cfg_we) begin
            case (cfg_addr)
                CFG_ROWS: rows_cfg_next = cfg_wdata;
                default:  cols_cfg_next = cfg_wdata;
            endcase
        end

        // take the request
        if (uw.fetch) begin
            clr_next = '0;
        end
        if (s_accept) begin
            mode_next  = s_tuser;
            srow_next  = s_tdata[4:0];
            scol_next  = s_tdata[9:5];
            rv_lo_next = s_tdata[11:10];
            rv_m3_next = mod3_16(s_tdata[25:10]);
        end

        if (uw.load_cur) begin
            cur_row_next = stk_q[CELL_W-1:CW];
            cur_col_next = stk_q[CW-1:0];
        end
        if (uw.cap) begin
            cand_next = mask_now;
        end
        if (uw.set_kind) begin
            kind_next    = uw.kind;
            anc_row_next = '0;
            anc_col_next = '0;
            down_next    = 1'b0;
        end

        // clearing pass over the visited store
        if (uw.clr_wr) begin
            vis_we    = 1'b1;
            vis_waddr = clr_reg;
            vis_wdata = 1'b0;
            clr_next  = clr_reg + CELL_W'(1);
        end

        // new maze: mark and push the start cell
        if (uw.start_wr) begin
            vis_we    = 1'b1;
            vis_waddr = {rsat9[RW-1:0], csat9[CW-1:0]};
            vis_wdata = 1'b1;
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = {rsat9[RW-1:0], csat9[CW-1:0]};
            sp_next   = SP_W'(1);
        end

        // carve: mark and push the chosen neighbor, anchor at upper or left cell
        if (uw.carve) begin
            vis_we    = 1'b1;
            vis_waddr = {new_row, new_col};
            vis_wdata = 1'b1;
            if (sp_reg < SP_W'(CELLS)) begin
                stk_we  = 1'b1;
                sp_next = sp_reg + SP_W'(1);
            end
            kind_next = EV_CARVED;
            down_next = (sel_dir == DIR_DOWN) || (sel_dir == DIR_UP);
            if ((sel_dir == DIR_DOWN) || (sel_dir == DIR_RIGHT)) begin
                anc_row_next = cur_row_reg;
                anc_col_next = cur_col_reg;
            end else begin
                anc_row_next = new_row;
                anc_col_next = new_col;
            end
        end

        if (uw.pop) begin
            sp_next = sp_dec;
        end

        // output register
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (uw.emit && !out_busy) begin
            m_valid_next = 1'b1;
            m_user_next  = kind_reg;
            m_data_next  = {depth_w[10:0], down_reg, anc_col_w[4:0], anc_row_w[4:0],
                            top_col_w[4:0], top_row_w[4:0]};
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg      <= UA_FETCH;
            rows_cfg_reg <= 6'd32;
            cols_cfg_reg <= 6'd32;
            sp_reg       <= '0;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            upc_reg      <= upc_next;
            rows_cfg_reg <= rows_cfg_next;
            cols_cfg_reg <= cols_cfg_next;
            sp_reg       <= sp_next;
            clr_reg      <= clr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        srow_reg    <= srow_next;
        scol_reg    <= scol_next;
        rv_lo_reg   <= rv_lo_next;
        rv_m3_reg   <= rv_m3_next;
        cur_row_reg <= cur_row_next;
        cur_col_reg <= cur_col_next;
        cand_reg    <= cand_next;
        kind_reg    <= kind_next;
        anc_row_reg <= anc_row_next;
        anc_col_reg <= anc_col_next;
        down_reg    <= down_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    // visited store
    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (uw.vis_rd) begin
            vis_q <= vis_mem[vis_raddr];
        end
    end

    // path stack
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (uw.stk_rd) begin
            stk_q <= stk_mem[stk_raddr];
        end
    end

    // stack depth never passes the cell count
    assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(CELLS))
        else $error("path stack depth beyond cell count");

    // an accepted request always goes to dispatch next
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> upc_reg == UA_DISP)
        else $error("accepted request not dispatched");

    // a new result appears only from the emit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg ##1 m_valid_reg |-> $past(uw.emit))
        else $error("result raised outside emit step");

    // carving needs at least one candidate
    assert property (@(posedge aclk) disable iff (!aresetn)
        uw.carve |-> cand_reg != 4'd0)
        else $error("carve with no candidate");

    // single-port visited store: no read and write together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(uw.vis_rd && vis_we))
        else $error("visited store read and write in one cycle");

endmodule

// ===== dv/tb_top.sv =====
module tb_top
    import mbc_pkg::*;
();

    localparam int GRID_ROWS   = 32;
    localparam int GRID_COLS   = 32;
    localparam int GRID_CELLS  = GRID_ROWS * GRID_COLS;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS  = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 6000;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef struct packed {
        ev_kind_t    kind;
        logic [4:0]  top_row;
        logic [4:0]  top_col;
        logic [4:0]  anchor_row;
        logic [4:0]  anchor_col;
        logic        carve_down;
        logic [10:0] depth;
    } carve_result_t;

    // maze predictor and queue of results still to come
    class maze_scoreboard;
        logic [5:0]    rows_reg;
        logic [5:0]    cols_reg;
        bit            visited[GRID_CELLS];
        int            path[GRID_CELLS];
        int            depth;
        carve_result_t due_q[$];
        int            errors;
        int            requests;
        int            starts;
        int            kind_seen[4];

        function new();
            rows_reg = 6'd32;
            cols_reg = 6'd32;
            depth    = 0;
            errors   = 0;
            requests = 0;
            starts   = 0;
            foreach (visited[i]) visited[i] = 1'b0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        static function int dim_eff(logic [5:0] v, int maxv);
            if (v == 6'd0) return 1;
            if (int'(v) > maxv) return maxv;
            return int'(v);
        endfunction

        function void set_register(logic idx, logic [5:0] v);
            if (idx == CFG_ROWS) rows_reg = v;
            else cols_reg = v;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // work out the result of one accepted request
        function void note_request(logic mode, logic [4:0] srow, logic [4:0] scol,
                                   logic [15:0] rnd);
            carve_result_t res;
            int   rows, cols, r, c, n, k, ncell, nr, nc;
            int   cand_r[4], cand_c[4];
            dir_t cand_d[4];
            res  = '0;
            rows = dim_eff(rows_reg, GRID_ROWS);
            cols = dim_eff(cols_reg, GRID_COLS);
            requests++;
            if (mode == MODE_START) begin
                starts++;
                r = (int'(srow) >= rows) ? rows - 1 : int'(srow);
                c = (int'(scol) >= cols) ? cols - 1 : int'(scol);
                foreach (visited[i]) visited[i] = 1'b0;
                path[0] = r * GRID_COLS + c;
                visited[r * GRID_COLS + c] = 1'b1;
                depth = 1;
                res.kind = EV_STARTED;
            end else if (depth == 0) begin
                res.kind = EV_FINISHED;
            end else begin
                r = path[depth - 1] / GRID_COLS;
                c = path[depth - 1] % GRID_COLS;
                n = 0;
                // range test against the registers as they stand now
                if (r + 1 < rows && c < cols && !visited[(r + 1) * GRID_COLS + c]) begin
                    cand_r[n] = r + 1; cand_c[n] = c; cand_d[n] = DIR_DOWN; n++;
                end
                if (r >= 1 && r - 1 < rows && c < cols &&
                    !visited[(r - 1) * GRID_COLS + c]) begin
                    cand_r[n] = r - 1; cand_c[n] = c; cand_d[n] = DIR_UP; n++;
                end
                if (c + 1 < cols && r < rows && !visited[r * GRID_COLS + c + 1]) begin
                    cand_r[n] = r; cand_c[n] = c + 1; cand_d[n] = DIR_RIGHT; n++;
                end
                if (c >= 1 && c - 1 < cols && r < rows &&
                    !visited[r * GRID_COLS + c - 1]) begin
                    cand_r[n] = r; cand_c[n] = c - 1; cand_d[n] = DIR_LEFT; n++;
                end
                if (n == 0) begin
                    depth--;
                    res.kind = EV_BACKTRACK;
                end else begin
                    k  = int'(rnd) % n;
                    nr = cand_r[k];
                    nc = cand_c[k];
                    ncell = nr * GRID_COLS + nc;
                    visited[ncell] = 1'b1;
                    if (depth < GRID_CELLS) begin
                        path[depth] = ncell;
                        depth++;
                    end
                    res.kind = EV_CARVED;
                    // passage is anchored at its upper or left cell
                    case (cand_d[k])
                        DIR_DOWN: begin
                            res.anchor_row = 5'(r);  res.anchor_col = 5'(c);  res.carve_down = 1'b1;
                        end
                        DIR_UP: begin
                            res.anchor_row = 5'(nr); res.anchor_col = 5'(nc); res.carve_down = 1'b1;
                        end
                        DIR_RIGHT: begin
                            res.anchor_row = 5'(r);  res.anchor_col = 5'(c);  res.carve_down = 1'b0;
                        end
                        default: begin
                            res.anchor_row = 5'(nr); res.anchor_col = 5'(nc); res.carve_down = 1'b0;
                        end
                    endcase
                end
            end
            if (depth > 0) begin
                res.top_row = 5'(path[depth - 1] / GRID_COLS);
                res.top_col = 5'(path[depth - 1] % GRID_COLS);
            end
            res.depth = 11'(depth);
            due_q.push_back(res);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        // compare one accepted result with the oldest outstanding one
        task check_result(logic [1:0] kind, logic [31:0] data);
            carve_result_t want;
            kind_seen[kind]++;
            if (due_q.size() == 0) begin
                report_mismatch("result with no request outstanding", int'(kind), -1);
            end else begin
                want = due_q.pop_front();
                if (kind != want.kind) report_mismatch("event_kind", kind, want.kind);
                if (data[4:0] != want.top_row)
                    report_mismatch("top_row", data[4:0], want.top_row);
                if (data[9:5] != want.top_col)
                    report_mismatch("top_col", data[9:5], want.top_col);
                if (data[14:10] != want.anchor_row)
                    report_mismatch("anchor_row", data[14:10], want.anchor_row);
                if (data[19:15] != want.anchor_col)
                    report_mismatch("anchor_col", data[19:15], want.anchor_col);
                if (data[20] != want.carve_down)
                    report_mismatch("carve_down", data[20], want.carve_down);
                if (data[31:21] != want.depth)
                    report_mismatch("stack_depth", data[31:21], want.depth);
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_addr;
    logic [5:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    maze_scoreboard sb;
    bit calm;
    bit hold_req;
    int settings_used;

    maze_backtracker_carver #(
        .MAX_ROWS(GRID_ROWS),
        .MAX_COLS(GRID_COLS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // offer one request, with an occasional short gap first
    task automatic send_request(input logic mode, input logic [4:0] srow,
                                input logic [4:0] scol, input logic [15:0] rnd);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'd0, rnd, scol, srow};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(mode, srow, scol, rnd);
    endtask

    // sender waits until every outstanding result has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_dims(input logic [5:0] rows_v, input logic [5:0] cols_v);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_ROWS;
        cfg_wdata <= rows_v;
        @(posedge aclk);
        cfg_addr  <= CFG_COLS;
        cfg_wdata <= cols_v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_register(CFG_ROWS, rows_v);
        sb.set_register(CFG_COLS, cols_v);
        settings_used++;
    endtask

    function automatic logic [5:0] pick_dim();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 6'd0;
        if (sel == 1) return 6'($urandom_range(32, 63));
        if (sel == 2) return 6'd32;
        return 6'($urandom_range(1, 8));
    endfunction

    function automatic logic [15:0] pick_rnd();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    // result side: random back-pressure, one long hold-off on request
    initial begin : result_sink
        int stall_left;
        bit hold_taken;
        stall_left = 0;
        hold_taken = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no request or result taken
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("timeout: %0d cycles without progress", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int random_sent;
        int phase;
        int eff_r, eff_c, cells, nsteps;
        logic [5:0] rows_v, cols_v;

        sb = new();
        calm = 1'b0;
        hold_req = 1'b0;
        settings_used = 0;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_ROWS;
        cfg_wdata <= 6'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 32'd0;
        s_tuser   <= MODE_START;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // step on an empty stack right after reset
        send_request(MODE_STEP, 5'd0, 5'd0, 16'h0000);
        // zero registers act as one; start cell saturates into a 1 x 1 grid
        wait_drain();
        write_dims(6'd0, 6'd0);
        send_request(MODE_START, 5'd31, 5'd31, 16'hFFFF);
        send_request(MODE_STEP, 5'd31, 5'd31, 16'hFFFF);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'h0000);
        // oversized registers act as the full grid; corner start
        wait_drain();
        write_dims(6'd63, 6'd33);
        send_request(MODE_START, 5'd31, 5'd31, 16'h0000);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'hFFFF);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'h0000);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'h8000);
        // interior start: four candidates; later an edge start: three
        wait_drain();
        write_dims(6'd3, 6'd3);
        send_request(MODE_START, 5'd1, 5'd1, 16'h0000);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'd3);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'd5);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'd2);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'd1);
        send_request(MODE_START, 5'd0, 5'd1, 16'h0000);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'd5);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'hFFFF);
        // shrink the grid under a maze in progress
        wait_drain();
        write_dims(6'd2, 6'd32);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'd7);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'd9);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'd0);
        send_request(MODE_STEP, 5'd0, 5'd0, 16'd1);

        // random mazes: mostly start then carve, some noise starts
        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_drain();
            phase++;
            if ($urandom_range(0, 11) == 0) begin
                rows_v = 6'd32;
                cols_v = 6'd32;
            end else begin
                rows_v = pick_dim();
                cols_v = pick_dim();
            end
            write_dims(rows_v, cols_v);
            eff_r = maze_scoreboard::dim_eff(rows_v, GRID_ROWS);
            eff_c = maze_scoreboard::dim_eff(cols_v, GRID_COLS);
            cells = eff_r * eff_c;
            nsteps = (cells > 100) ? $urandom_range(40, 200)
                                   : $urandom_range(cells, 2 * cells + 4);
            if (phase == 3) begin
                // long hold-off on the result side while requests keep coming
                if (nsteps < 30) nsteps = 30;
                hold_req = 1'b1;
            end
            // some phases keep the previous maze under the new registers
            if (phase == 1 || $urandom_range(0, 3) != 0) begin
                send_request(MODE_START, 5'($urandom), 5'($urandom), pick_rnd());
                random_sent++;
            end
            for (int i = 0; i < nsteps && random_sent < RANDOM_ITEMS; i++) begin
                calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
                if ($urandom_range(0, 39) == 0)
                    send_request(MODE_START, 5'($urandom), 5'($urandom), pick_rnd());
                else
                    send_request(MODE_STEP, 5'($urandom), 5'($urandom), pick_rnd());
                random_sent++;
            end
        end

        // drain and let the block settle
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch("results never delivered", 0, sb.pending());

        $display("covered %0d requests (%0d starts) over %0d register settings",
                 sb.requests, sb.starts, settings_used);
        $display("results: %0d started, %0d carved, %0d backtracked, %0d finished",
                 sb.kind_seen[EV_STARTED], sb.kind_seen[EV_CARVED],
                 sb.kind_seen[EV_BACKTRACK], sb.kind_seen[EV_FINISHED]);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/mbc_pkg.sv
design/maze_backtracker_carver.sv
dv/tb_top.sv
